// ===== hdl/multi_joint_pid_with_phase_gains_unit_macros.svh =====
// Assertion macros used by the checker file
`ifndef MULTI_JOINT_PID_WITH_PHASE_GAINS_UNIT_MACROS_SVH
`define MULTI_JOINT_PID_WITH_PHASE_GAINS_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define MJPG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mjpg check failed");

// Next-cycle implication, disabled while reset is low
`define MJPG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mjpg check failed");

`endif

// ===== hdl/mjpg_pkg.sv =====
// Shared widths, codes and stage types of the joint PID block
package mjpg_pkg;

    localparam int JOINT_W = 4;
    localparam int PHASE_W = 2;
    localparam int KIND_W  = 2;
    localparam int GAIN_W  = 16;
    localparam int DATA_W  = 32;
    localparam int ERR_W   = DATA_W + 1;
    localparam int INTG_W  = 40;
    localparam int GAINS_W = 3 * GAIN_W;

    localparam int P_KP_W = GAIN_W + ERR_W;
    localparam int P_KV_W = GAIN_W + DATA_W;
    localparam int P_KI_W = GAIN_W + INTG_W;
    localparam int SUM_W  = P_KI_W + 2;
    localparam int T_W    = SUM_W + 1;
    localparam int FRAC_W = 8;
    localparam int D_W    = T_W - FRAC_W;

    localparam logic CMD_GAIN   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [PHASE_W-1:0] PHASE_LIFTOFF = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_LANDED  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_KP = 2'd0;
    localparam logic [KIND_W-1:0] KIND_KV = 2'd1;
    localparam logic [KIND_W-1:0] KIND_KI = 2'd2;

    // Accepted beat after decode
    typedef struct packed {
        logic               cmd;
        logic [JOINT_W-1:0] joint;
        logic [KIND_W-1:0]  kind;
        logic [GAIN_W-1:0]  gain;
        logic [ERR_W-1:0]   err;
        logic [DATA_W-1:0]  vel;
        logic [DATA_W-1:0]  load;
    } t_item;

    // One gain-memory word
    typedef struct packed {
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kv;
        logic [GAIN_W-1:0] kp;
    } t_gains;

    // Operands handed from the state stage to the multiply stage
    typedef struct packed {
        logic [JOINT_W-1:0] joint;
        logic [ERR_W-1:0]   err;
        logic [DATA_W-1:0]  vel;
        logic [DATA_W-1:0]  load;
        logic [INTG_W-1:0]  integ;
        t_gains             gains;
    } t_term;

endpackage

// ===== hdl/mjpg_ifs.sv =====
// Sample and drive channel interfaces
interface mjpg_smp_if import mjpg_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      cmd;
    logic        [JOINT_W-1:0] joint;
    logic        [PHASE_W-1:0] phase;
    logic        [KIND_W-1:0]  gain_kind;
    logic signed [GAIN_W-1:0]  gain_value;
    logic signed [DATA_W-1:0]  position;
    logic signed [DATA_W-1:0]  target_position;
    logic signed [DATA_W-1:0]  velocity;
    logic signed [DATA_W-1:0]  load_in;

    modport source (
        output valid, cmd, joint, phase, gain_kind, gain_value,
               position, target_position, velocity, load_in,
        input  ready
    );
    modport sink (
        input  valid, cmd, joint, phase, gain_kind, gain_value,
               position, target_position, velocity, load_in,
        output ready
    );
endinterface

interface mjpg_drv_if import mjpg_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic        [JOINT_W-1:0] out_joint;
    logic signed [DATA_W-1:0]  drive;

    modport source (output valid, out_joint, drive, input ready);
    modport sink   (input valid, out_joint, drive, output ready);
endinterface

// ===== hdl/multi_joint_pid_with_phase_gains_unit.sv =====
// Per-joint PID drive with liftoff and landed gain sets: top level
// An accepted sample passes the state stage register, then the product, sum and output registers.
// Throughput: one beat per cycle, gain write or sample, as long as drive beats drain.
// The pace is set by the single read-modify-write port pair on the state memories.
// Reset (i_rst_n low, synchronous) empties every stage and clears the entry valid
// bits, so all gains and integrals read as zero; no clearing pass is needed.
module multi_joint_pid_with_phase_gains_unit import mjpg_pkg::*; #(
    parameter int JOINTS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    mjpg_smp_if.sink        i_smp,
    mjpg_drv_if.source      o_drv
);
    // Entries: liftoff set at 0..JOINTS-1, landed set at JOINTS..2*JOINTS-1
    localparam int DEPTH = 2 * JOINTS;
    localparam int IDX_W = $clog2(DEPTH);

    logic               accept;
    logic               phase_ok;
    logic               joint_ok;
    logic               act;
    logic [IDX_W-1:0]   idx;
    t_item              item;
    logic               st_ready;
    logic               term_valid;
    t_term              term;
    logic               term_ready;
    logic               drv_valid;
    logic [JOINT_W-1:0] drv_joint;
    logic [DATA_W-1:0]  drv_value;

    // Decode: phase 0/3 and joints past the configured count are swallowed
    // at the input without touching state or producing a beat.
    always_comb begin
        accept   = i_smp.valid && i_smp.ready;
        phase_ok = (i_smp.phase == PHASE_LIFTOFF) || (i_smp.phase == PHASE_LANDED);
        joint_ok = {3'b000, i_smp.joint} < 7'(JOINTS);
        act      = phase_ok && joint_ok;

        idx = IDX_W'(i_smp.joint)
            + ((i_smp.phase == PHASE_LANDED) ? IDX_W'(JOINTS) : '0);

        item.cmd   = i_smp.cmd;
        item.joint = i_smp.joint;
        item.kind  = i_smp.gain_kind;
        item.gain  = i_smp.gain_value;
        // position error, exact in 33 bits
        item.err   = {i_smp.position[DATA_W-1], i_smp.position}
                   - {i_smp.target_position[DATA_W-1], i_smp.target_position};
        item.vel   = i_smp.velocity;
        item.load  = i_smp.load_in;
    end

    assign i_smp.ready = st_ready;

    // Stage 1: memory read at accept, merge or integrate, write back on leave.
    // A write leaving on the same edge a read of that entry is issued is forwarded.
    mjpg_state #(
        .JOINTS (JOINTS)
    ) u_state (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_acc        (accept && act),
        .i_idx        (idx),
        .i_item       (item),
        .o_ready      (st_ready),
        .o_term_valid (term_valid),
        .o_term       (term),
        .i_term_ready (term_ready)
    );

    // Stages 2..4: three parallel products, sum with load, floor and saturate.
    // Each stage holds its beat independently so bubbles close up under stall.
    mjpg_mac u_mac (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_term_valid (term_valid),
        .i_term       (term),
        .o_term_ready (term_ready),
        .o_valid      (drv_valid),
        .o_joint      (drv_joint),
        .o_drive      (drv_value),
        .i_ready      (o_drv.ready)
    );

    assign o_drv.valid     = drv_valid;
    assign o_drv.out_joint = drv_joint;
    assign o_drv.drive     = drv_value;

endmodule

// ===== hdl/mjpg_state.sv =====
// Gain and integral memories with read-modify-write stage and forwarding
module mjpg_state import mjpg_pkg::*; #(
    parameter int JOINTS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_acc,
    input  logic [$clog2(2*JOINTS)-1:0]       i_idx,
    input  t_item                             i_item,
    output logic                              o_ready,
    output logic                              o_term_valid,
    output t_term                             o_term,
    input  logic                              i_term_ready
);
    localparam int DEPTH = 2 * JOINTS;
    localparam int IDX_W = $clog2(DEPTH);

    logic [GAINS_W-1:0] r_gain_mem [DEPTH];
    logic [INTG_W-1:0]  r_intg_mem [DEPTH];
    logic [DEPTH-1:0]   r_gain_vld;
    logic [DEPTH-1:0]   r_intg_vld;

    logic [GAINS_W-1:0] r_gain_rd;
    logic [INTG_W-1:0]  r_intg_rd;
    logic               r_grd_vld;
    logic               r_ird_vld;
    logic               r_gfwd;
    logic               r_ifwd;
    t_gains             r_gfwd_data;
    logic [INTG_W-1:0]  r_ifwd_data;
    logic               r_s1_v;
    t_item              r_s1;
    logic [IDX_W-1:0]   r_s1_idx;

    logic               s1_adv;
    logic               gain_we;
    logic               intg_we;
    t_gains             gains_old;
    t_gains             gains_new;
    logic [INTG_W-1:0]  intg_old;
    logic [INTG_W:0]    intg_sum;
    logic [INTG_W-1:0]  intg_new;

    always_comb begin
        // gain writes retire here; samples wait for the multiply stage
        s1_adv  = r_s1_v && ((r_s1.cmd == CMD_GAIN) || i_term_ready);
        gain_we = s1_adv && (r_s1.cmd == CMD_GAIN);
        intg_we = s1_adv && (r_s1.cmd == CMD_SAMPLE);

        gains_old = r_gfwd ? r_gfwd_data : (r_grd_vld ? t_gains'(r_gain_rd) : '0);
        intg_old  = r_ifwd ? r_ifwd_data : (r_ird_vld ? r_intg_rd : '0);

        gains_new = gains_old;
        case (r_s1.kind)
            KIND_KP: gains_new.kp = r_s1.gain;
            KIND_KV: gains_new.kv = r_s1.gain;
            KIND_KI: gains_new.ki = r_s1.gain;
            default: gains_new = gains_old;
        endcase

        intg_sum = {intg_old[INTG_W-1], intg_old}
                 + {{(INTG_W + 1 - ERR_W){r_s1.err[ERR_W-1]}}, r_s1.err};
        if (intg_sum[INTG_W] == intg_sum[INTG_W-1]) begin
            intg_new = intg_sum[INTG_W-1:0];
        end else if (intg_sum[INTG_W]) begin
            intg_new = {1'b1, {(INTG_W - 1){1'b0}}};
        end else begin
            intg_new = {1'b0, {(INTG_W - 1){1'b1}}};
        end

        o_ready      = !r_s1_v || s1_adv;
        o_term_valid = r_s1_v && (r_s1.cmd == CMD_SAMPLE);
        o_term.joint = r_s1.joint;
        o_term.err   = r_s1.err;
        o_term.vel   = r_s1.vel;
        o_term.load  = r_s1.load;
        o_term.integ = intg_new;
        o_term.gains = gains_old;
    end

    // memories and stage payload
    always_ff @(posedge i_clk) begin
        if (gain_we) begin
            r_gain_mem[r_s1_idx] <= gains_new;
        end
        if (intg_we) begin
            r_intg_mem[r_s1_idx] <= intg_new;
        end
        if (i_acc) begin
            r_gain_rd   <= r_gain_mem[i_idx];
            r_intg_rd   <= r_intg_mem[i_idx];
            r_s1        <= i_item;
            r_s1_idx    <= i_idx;
            r_gfwd_data <= gains_new;
            r_ifwd_data <= intg_new;
        end
    end

    // entry valid bits, stage valid and forward flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_vld <= '0;
            r_intg_vld <= '0;
            r_grd_vld  <= 1'b0;
            r_ird_vld  <= 1'b0;
            r_gfwd     <= 1'b0;
            r_ifwd     <= 1'b0;
            r_s1_v     <= 1'b0;
        end else begin
            if (gain_we) begin
                r_gain_vld[r_s1_idx] <= 1'b1;
            end
            if (intg_we) begin
                r_intg_vld[r_s1_idx] <= 1'b1;
            end
            if (i_acc) begin
                r_grd_vld <= r_gain_vld[i_idx];
                r_ird_vld <= r_intg_vld[i_idx];
                // write landing on the same edge as the read: take the new word
                r_gfwd    <= gain_we && (r_s1_idx == i_idx);
                r_ifwd    <= intg_we && (r_s1_idx == i_idx);
                r_s1_v    <= 1'b1;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
        end
    end

endmodule

// ===== hdl/mjpg_mac.sv =====
// Multiply, sum, floor scaling and saturation stages with output register
module mjpg_mac import mjpg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_term_valid,
    input  t_term              i_term,
    output logic               o_term_ready,
    output logic               o_valid,
    output logic [JOINT_W-1:0] o_joint,
    output logic [DATA_W-1:0]  o_drive,
    input  logic               i_ready
);
    logic                      r_s2_v;
    logic        [JOINT_W-1:0] r_s2_joint;
    logic        [DATA_W-1:0]  r_s2_load;
    logic signed [P_KP_W-1:0]  r_p_kp;
    logic signed [P_KV_W-1:0]  r_p_kv;
    logic signed [P_KI_W-1:0]  r_p_ki;

    logic                      r_s3_v;
    logic        [JOINT_W-1:0] r_s3_joint;
    logic signed [T_W-1:0]     r_t;

    logic                      r_o_v;
    logic        [JOINT_W-1:0] r_o_joint;
    logic        [DATA_W-1:0]  r_o_drive;

    logic                      o_en;
    logic                      s3_en;
    logic                      s2_en;
    logic signed [P_KP_W-1:0]  p_kp;
    logic signed [P_KV_W-1:0]  p_kv;
    logic signed [P_KI_W-1:0]  p_ki;
    logic signed [SUM_W-1:0]   sum;
    logic signed [T_W-1:0]     t;
    logic        [D_W-1:0]     d;
    logic        [DATA_W-1:0]  d_sat;

    always_comb begin
        o_en  = !r_o_v || i_ready;
        s3_en = !r_s3_v || o_en;
        s2_en = !r_s2_v || s3_en;
        o_term_ready = s2_en;

        p_kp = $signed(i_term.gains.kp) * $signed(i_term.err);
        p_kv = $signed(i_term.gains.kv) * $signed(i_term.vel);
        p_ki = $signed(i_term.gains.ki) * $signed(i_term.integ);

        sum = SUM_W'(r_p_kp) + SUM_W'(r_p_kv) + SUM_W'(r_p_ki);
        t   = T_W'($signed({r_s2_load, {FRAC_W{1'b0}}})) - T_W'(sum);

        // arithmetic shift floors toward minus infinity
        d = r_t[T_W-1:FRAC_W];
        if ((&d[D_W-1:DATA_W-1]) || !(|d[D_W-1:DATA_W-1])) begin
            d_sat = d[DATA_W-1:0];
        end else if (d[D_W-1]) begin
            d_sat = {1'b1, {(DATA_W - 1){1'b0}}};
        end else begin
            d_sat = {1'b0, {(DATA_W - 1){1'b1}}};
        end

        o_valid = r_o_v;
        o_joint = r_o_joint;
        o_drive = r_o_drive;
    end

    always_ff @(posedge i_clk) begin
        if (s2_en && i_term_valid) begin
            r_s2_joint <= i_term.joint;
            r_s2_load  <= i_term.load;
            r_p_kp     <= p_kp;
            r_p_kv     <= p_kv;
            r_p_ki     <= p_ki;
        end
        if (s3_en && r_s2_v) begin
            r_s3_joint <= r_s2_joint;
            r_t        <= t;
        end
        if (o_en && r_s3_v) begin
            r_o_joint <= r_s3_joint;
            r_o_drive <= d_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            if (s2_en) begin
                r_s2_v <= i_term_valid;
            end
            if (s3_en) begin
                r_s3_v <= r_s2_v;
            end
            if (o_en) begin
                r_o_v <= r_s3_v;
            end
        end
    end

endmodule

// ===== hdl/mjpg_chk.sv =====
// Port-level checker for the joint PID block, bound to the top level
`include "multi_joint_pid_with_phase_gains_unit_macros.svh"

module mjpg_chk import mjpg_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [JOINT_W-1:0] i_out_joint,
    input logic [DATA_W-1:0]  i_out_drive
);
    // a stalled drive beat holds
    `MJPG_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_drive) && $stable(i_out_joint))

    // input side never blocks while the output side can move
    `MJPG_ASSERT_NOW(a_in_flows, i_clk, i_rst_n, !i_out_valid || i_out_ready, i_in_ready)

    // no drive beat until a beat accepted after reset has passed through the stages
    `MJPG_ASSERT_NOW(a_rst_quiet, i_clk, i_rst_n, $past(!i_rst_n) || $past(!i_rst_n, 2) || $past(!i_rst_n, 3), !i_out_valid)

    // a beat accepted just after reset cannot reach the output at once
    `MJPG_ASSERT_NEXT(a_min_lat, i_clk, i_rst_n, $past(!i_rst_n) && i_in_valid && i_in_ready, !i_out_valid)

endmodule

bind multi_joint_pid_with_phase_gains_unit mjpg_chk u_mjpg_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_smp.valid),
    .i_in_ready  (i_smp.ready),
    .i_out_valid (o_drv.valid),
    .i_out_ready (o_drv.ready),
    .i_out_joint (o_drv.out_joint),
    .i_out_drive (o_drv.drive)
);

// ===== verif/multi_joint_pid_with_phase_gains_unit_tb.sv =====
// Self-checking testbench for the multi-joint PID drive block with phase gain sets
`timescale 1ns / 100ps

package mjpg_tb_pkg;
    import mjpg_pkg::*;

    localparam int JOINT_COUNT = 16;
    localparam int SLOT_COUNT  = 2 * JOINT_COUNT;

    // Phase and kind codes that the block ignores
    localparam logic [PHASE_W-1:0] PHASE_OTHER = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_SPARE = 2'd3;
    localparam logic [KIND_W-1:0]  KIND_NONE   = 2'd3;

    localparam longint INTG_MAX  = 64'sd549755813887;
    localparam longint INTG_MIN  = -64'sd549755813888;
    localparam longint DRIVE_MAX = 64'sd2147483647;
    localparam longint DRIVE_MIN = -64'sd2147483648;

    typedef struct packed {
        logic                      cmd;
        logic        [JOINT_W-1:0] joint;
        logic        [PHASE_W-1:0] phase;
        logic        [KIND_W-1:0]  kind;
        logic signed [GAIN_W-1:0]  gain;
        logic signed [DATA_W-1:0]  position;
        logic signed [DATA_W-1:0]  target;
        logic signed [DATA_W-1:0]  velocity;
        logic signed [DATA_W-1:0]  load;
    } t_smp_beat;

    typedef struct packed {
        logic        [JOINT_W-1:0] joint;
        logic signed [DATA_W-1:0]  drive;
    } t_drive_beat;

    class drive_scoreboard;
        logic signed [GAIN_W-1:0] kp_tab [SLOT_COUNT];
        logic signed [GAIN_W-1:0] kv_tab [SLOT_COUNT];
        logic signed [GAIN_W-1:0] ki_tab [SLOT_COUNT];
        logic signed [INTG_W-1:0] integ_tab [SLOT_COUNT];
        t_drive_beat              drive_q [$];
        int                       errors;

        function new();
            for (int i = 0; i < SLOT_COUNT; i++) begin
                kp_tab[i]    = '0;
                kv_tab[i]    = '0;
                ki_tab[i]    = '0;
                integ_tab[i] = '0;
            end
            errors = 0;
        endfunction

        // Apply one accepted input beat to the gain/integral tables
        function void note_beat(t_smp_beat b);
            int unsigned slot;
            longint      err;
            longint      acc;
            longint      sum;
            longint      t;
            longint      d;
            t_drive_beat e;
            if (b.phase != PHASE_LIFTOFF && b.phase != PHASE_LANDED) return;
            // joint is 4 bits wide and JOINT_COUNT is 16, so it is always in range
            slot = (b.phase == PHASE_LANDED ? JOINT_COUNT : 0) + int'(b.joint);
            if (b.cmd == CMD_GAIN) begin
                case (b.kind)
                    KIND_KP: kp_tab[slot] = b.gain;
                    KIND_KV: kv_tab[slot] = b.gain;
                    KIND_KI: ki_tab[slot] = b.gain;
                    default: ;
                endcase
                return;
            end
            err = longint'(b.position) - longint'(b.target);
            acc = longint'(integ_tab[slot]) + err;
            if (acc > INTG_MAX) acc = INTG_MAX;
            if (acc < INTG_MIN) acc = INTG_MIN;
            integ_tab[slot] = acc[INTG_W-1:0];
            sum = longint'(kp_tab[slot]) * err
                + longint'(kv_tab[slot]) * longint'(b.velocity)
                + longint'(ki_tab[slot]) * acc;
            t = longint'(b.load) * 256 - sum;
            d = t >>> 8;
            if (d > DRIVE_MAX) d = DRIVE_MAX;
            if (d < DRIVE_MIN) d = DRIVE_MIN;
            e.joint = b.joint;
            e.drive = d[DATA_W-1:0];
            drive_q.push_back(e);
        endfunction

        function void check_beat(logic [JOINT_W-1:0] joint, logic signed [DATA_W-1:0] drive);
            t_drive_beat e;
            if (drive_q.size() == 0) begin
                $error("unexpected drive beat: out_joint %0d drive %0d", joint, drive);
                errors++;
                return;
            end
            e = drive_q.pop_front();
            if (joint !== e.joint) begin
                $error("out_joint: expected %0d, actual %0d", e.joint, joint);
                errors++;
            end
            if (drive !== e.drive) begin
                $error("drive: expected %0d, actual %0d", e.drive, drive);
                errors++;
            end
        endfunction

        function int outstanding();
            return drive_q.size();
        endfunction
    endclass
endpackage

module multi_joint_pid_with_phase_gains_unit_tb;
    import mjpg_pkg::*;
    import mjpg_tb_pkg::*;

    // Cycles with no beat on either channel before the run is declared hung.
    // Worst legit quiet stretch is the receiver hold of HOLD_CYCLES plus
    // geometric stalls at 73 % idle, and the limit leaves a wide margin.
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 135;
    localparam int DRAIN_CYCLES = 8;     // time for the pipeline stages to empty, plus slack

    // Joints driven hard in one direction so their integrals hit the rails
    localparam logic [JOINT_W-1:0] WINDUP_POS_JOINT = 4'd7;   // landed set
    localparam logic [JOINT_W-1:0] WINDUP_NEG_JOINT = 4'd8;   // liftoff set

    localparam logic signed [DATA_W-1:0] D_MAX = 32'sh7fffffff;
    localparam logic signed [DATA_W-1:0] D_MIN = 32'sh80000000;
    localparam logic signed [GAIN_W-1:0] G_MAX = 16'sh7fff;
    localparam logic signed [GAIN_W-1:0] G_MIN = 16'sh8000;

    logic i_clk;
    logic i_rst_n;

    mjpg_smp_if smp ();
    mjpg_drv_if drv ();

    multi_joint_pid_with_phase_gains_unit #(
        .JOINTS (JOINT_COUNT)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp),
        .o_drv   (drv)
    );

    drive_scoreboard sb = new();

    // Idle percentages, switched by the main sequence between phases
    int unsigned src_idle_pct;
    int unsigned sink_idle_pct;
    // Set by the main sequence; the receiver process picks it up and
    // counts the hold-off itself
    bit          hold_req;
    t_smp_beat   directed_q [$];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Beat builders
    // ------------------------------------------------------------------
    function automatic t_smp_beat gain_beat(logic [JOINT_W-1:0] joint,
                                            logic [PHASE_W-1:0] phase,
                                            logic [KIND_W-1:0] kind,
                                            logic signed [GAIN_W-1:0] value);
        t_smp_beat b;
        b          = '0;
        b.cmd      = CMD_GAIN;
        b.joint    = joint;
        b.phase    = phase;
        b.kind     = kind;
        b.gain     = value;
        // payload fields unused by a gain write still carry noise
        b.position = $urandom;
        b.target   = $urandom;
        b.velocity = $urandom;
        b.load     = $urandom;
        return b;
    endfunction

    function automatic t_smp_beat sample_beat(logic [JOINT_W-1:0] joint,
                                              logic [PHASE_W-1:0] phase,
                                              logic signed [DATA_W-1:0] pos,
                                              logic signed [DATA_W-1:0] tgt,
                                              logic signed [DATA_W-1:0] vel,
                                              logic signed [DATA_W-1:0] load);
        t_smp_beat b;
        b          = '0;
        b.cmd      = CMD_SAMPLE;
        b.joint    = joint;
        b.phase    = phase;
        b.kind     = KIND_W'($urandom_range(0, 3));
        b.gain     = GAIN_W'($urandom);
        b.position = pos;
        b.target   = tgt;
        b.velocity = vel;
        b.load     = load;
        return b;
    endfunction

    // Half full-range words, half values near zero so the drive is not
    // always pinned at a rail
    function automatic logic signed [DATA_W-1:0] rand_word();
        if ($urandom_range(0, 1) == 0) return $urandom;
        return $urandom_range(0, 131071) - 65536;
    endfunction

    function automatic logic signed [GAIN_W-1:0] rand_gain();
        if ($urandom_range(0, 1) == 0) return GAIN_W'($urandom);
        return GAIN_W'($urandom_range(0, 1023) - 512);
    endfunction

    function automatic logic [PHASE_W-1:0] rand_gain_phase();
        return $urandom_range(0, 1) ? PHASE_LANDED : PHASE_LIFTOFF;
    endfunction

    // Two of three random beats wind up an integral (alternating the two
    // windup joints); the rest are gain writes, samples and ignored noise.
    function automatic t_smp_beat rand_beat(int unsigned k);
        t_smp_beat   b;
        int unsigned pick;
        if (k % 3 == 0) begin
            b = sample_beat(WINDUP_POS_JOINT, PHASE_LANDED,
                            D_MAX - $urandom_range(0, 255), D_MIN + $urandom_range(0, 255),
                            rand_word(), rand_word());
        end else if (k % 3 == 1) begin
            b = sample_beat(WINDUP_NEG_JOINT, PHASE_LIFTOFF,
                            D_MIN + $urandom_range(0, 255), D_MAX - $urandom_range(0, 255),
                            rand_word(), rand_word());
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                b = gain_beat(JOINT_W'($urandom_range(0, JOINT_COUNT - 1)), rand_gain_phase(),
                              KIND_W'($urandom_range(0, 2)), rand_gain());
            end else if (pick < 85) begin
                b = sample_beat(JOINT_W'($urandom_range(0, JOINT_COUNT - 1)), rand_gain_phase(),
                                rand_word(), rand_word(), rand_word(), rand_word());
            end else begin
                // anything goes: other phases, unknown kind
                b = '0;
                b.cmd      = 1'($urandom_range(0, 1));
                b.joint    = JOINT_W'($urandom);
                b.phase    = PHASE_W'($urandom);
                b.kind     = KIND_W'($urandom);
                b.gain     = GAIN_W'($urandom);
                b.position = $urandom;
                b.target   = $urandom;
                b.velocity = $urandom;
                b.load     = $urandom;
            end
        end
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Sender: entered and left at a falling edge. Random gaps precede each
    // beat; valid stays high across back-to-back beats.
    // ------------------------------------------------------------------
    task automatic send_beat(t_smp_beat b);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            smp.valid <= 1'b0;
            @(negedge i_clk);
        end
        smp.valid           <= 1'b1;
        smp.cmd             <= b.cmd;
        smp.joint           <= b.joint;
        smp.phase           <= b.phase;
        smp.gain_kind       <= b.kind;
        smp.gain_value      <= b.gain;
        smp.position        <= b.position;
        smp.target_position <= b.target;
        smp.velocity        <= b.velocity;
        smp.load_in         <= b.load;
        do @(posedge i_clk); while (!smp.ready);
        sb.note_beat(b);
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random ready, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        int hold_left;
        hold_left = 0;
        drv.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                drv.ready <= 1'b0;
                hold_left--;
            end else begin
                drv.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    // Drive beats are checked in the order they come out
    always @(posedge i_clk) begin
        if (i_rst_n && drv.valid && drv.ready) begin
            sb.check_beat(drv.out_joint, drv.drive);
        end
    end

    // Watchdog: only counts cycles in which neither channel moves a beat
    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((smp.valid && smp.ready) || (drv.valid && drv.ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned k;

        smp.valid           = 1'b0;
        smp.cmd             = CMD_GAIN;
        smp.joint           = '0;
        smp.phase           = PHASE_OTHER;
        smp.gain_kind       = KIND_KP;
        smp.gain_value      = '0;
        smp.position        = '0;
        smp.target_position = '0;
        smp.velocity        = '0;
        smp.load_in         = '0;
        hold_req            = 1'b0;
        src_idle_pct        = 20;
        sink_idle_pct       = 73;

        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part.
        // Zero gains after reset: drive is just the load
        directed_q.push_back(sample_beat(4'd0, PHASE_LIFTOFF, D_MAX, D_MIN, D_MIN, D_MAX));
        // Extreme gains on joint 0 liftoff
        directed_q.push_back(gain_beat(4'd0, PHASE_LIFTOFF, KIND_KP, G_MAX));
        directed_q.push_back(gain_beat(4'd0, PHASE_LIFTOFF, KIND_KV, G_MIN));
        directed_q.push_back(gain_beat(4'd0, PHASE_LIFTOFF, KIND_KI, G_MAX));
        // Writes that must be dropped: unknown kind, other phases
        directed_q.push_back(gain_beat(4'd0, PHASE_LIFTOFF, KIND_NONE, 16'sh1234));
        directed_q.push_back(gain_beat(4'd0, PHASE_OTHER, KIND_KP, 16'sh0000));
        directed_q.push_back(gain_beat(4'd0, PHASE_SPARE, KIND_KI, 16'sh0000));
        // Large positive correction pushes drive to the negative rail, then back
        directed_q.push_back(sample_beat(4'd0, PHASE_LIFTOFF, D_MAX, D_MIN, D_MIN, D_MIN));
        directed_q.push_back(sample_beat(4'd0, PHASE_LIFTOFF, D_MIN, D_MAX, D_MAX, D_MAX));
        // Samples in the other phases: no drive beat, no integral change
        directed_q.push_back(sample_beat(4'd0, PHASE_OTHER, D_MAX, D_MIN, D_MAX, D_MAX));
        directed_q.push_back(sample_beat(4'd15, PHASE_SPARE, D_MIN, D_MAX, D_MIN, D_MIN));
        // Opposite extremes on the landed set of the top joint
        directed_q.push_back(gain_beat(4'd15, PHASE_LANDED, KIND_KP, G_MIN));
        directed_q.push_back(gain_beat(4'd15, PHASE_LANDED, KIND_KV, G_MAX));
        directed_q.push_back(gain_beat(4'd15, PHASE_LANDED, KIND_KI, G_MIN));
        directed_q.push_back(sample_beat(4'd15, PHASE_LANDED, D_MIN, D_MAX, D_MAX, D_MAX));
        directed_q.push_back(sample_beat(4'd15, PHASE_LANDED, D_MAX, D_MIN, D_MIN, D_MAX));
        // Small values: fractional bits and floor rounding of negative results
        directed_q.push_back(sample_beat(4'd15, PHASE_LANDED, 32'sh00018000, 32'sh00010000,
                                         32'shffff8001, 32'sh00000100));
        directed_q.push_back(sample_beat(4'd3, PHASE_LANDED, '0, '0, '0, '0));
        // The two phase sets of one joint are independent
        directed_q.push_back(gain_beat(4'd0, PHASE_LANDED, KIND_KP, 16'sh0100));
        directed_q.push_back(sample_beat(4'd0, PHASE_LANDED, 32'sh00020000, '0, '0, '0));
        directed_q.push_back(sample_beat(4'd0, PHASE_LIFTOFF, 32'sh00020000, '0, '0, '0));
        // Nonzero integral gain on the windup joints so saturation shows in the drive
        directed_q.push_back(gain_beat(WINDUP_POS_JOINT, PHASE_LANDED, KIND_KI, 16'sh0100));
        directed_q.push_back(gain_beat(WINDUP_NEG_JOINT, PHASE_LIFTOFF, KIND_KI, 16'sh0100));
        foreach (directed_q[i]) send_beat(directed_q[i]);

        // Random part in three idling regimes; the windup stream runs
        // through all of them so both integrals reach their rails
        k = 0;
        for (int regime = 0; regime < 3; regime++) begin
            case (regime)
                0: begin
                    src_idle_pct  = 20;
                    sink_idle_pct = 73;
                end
                1: begin
                    src_idle_pct  = 73;
                    sink_idle_pct = 20;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                    // long receiver hold while the sender keeps offering:
                    // the pipeline fills and input ready drops
                    hold_req      = 1'b1;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_beat(rand_beat(k));
                k++;
            end
        end
        smp.valid <= 1'b0;

        while (sb.outstanding() > 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/mjpg_pkg.sv
hdl/mjpg_ifs.sv
hdl/mjpg_state.sv
hdl/mjpg_mac.sv
hdl/multi_joint_pid_with_phase_gains_unit.sv
hdl/mjpg_chk.sv
verif/multi_joint_pid_with_phase_gains_unit_tb.sv
